### hw/rtl/nmk_pkg.sv
// Shared types and constants for the Newmark-beta acceleration/velocity update.
`timescale 1ns / 1ps

package nmk_pkg;

  localparam int DATA_W    = 32;  // Q16.16 data word
  localparam int COEF_W    = 48;  // Q24.24 coefficient
  localparam int COEF_FRAC = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_DISP        = 3'd0,
    REG_COEF_VEL_ACC     = 3'd1,
    REG_COEF_ACC_ACC     = 3'd2,
    REG_COEF_OLD_ACC_VEL = 3'd3,
    REG_COEF_NEW_ACC_VEL = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] disp_new;
    logic signed [DATA_W-1:0] disp_old;
    logic signed [DATA_W-1:0] vel_old;
    logic signed [DATA_W-1:0] acc_old;
  } nmk_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] acc_new;
    logic signed [DATA_W-1:0] vel_new;
    logic                     saturated;
  } nmk_out_t;

endpackage

### hw/rtl/nmk_mul.sv
// Two-stage signed multiplier built from four registered partial products.
`timescale 1ns / 1ps

module nmk_mul #(
  parameter int AW = 48,
  parameter int BW = 33
) (
  input  logic                    clk,
  input  logic                    en1,
  input  logic                    en2,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int LA = AW / 2;
  localparam int LB = BW / 2;
  localparam int HA = AW - LA;
  localparam int HB = BW - LB;
  localparam int PW = AW + BW;

  logic signed [LA:0]   a_lo;
  logic signed [HA-1:0] a_hi;
  logic signed [LB:0]   b_lo;
  logic signed [HB-1:0] b_hi;

  logic signed [LA+LB+1:0] pp_ll;
  logic signed [LA+HB:0]   pp_lh;
  logic signed [HA+LB:0]   pp_hl;
  logic signed [HA+HB-1:0] pp_hh;

  // low halves are unsigned: prepend a zero sign bit
  assign a_lo = $signed({1'b0, a[LA-1:0]});
  assign a_hi = a[AW-1:LA];
  assign b_lo = $signed({1'b0, b[LB-1:0]});
  assign b_hi = b[BW-1:LB];

  always_ff @(posedge clk) begin
    if (en1) begin
      pp_ll <= a_lo * b_lo;
      pp_lh <= a_lo * b_hi;
      pp_hl <= a_hi * b_lo;
      pp_hh <= a_hi * b_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      p <= PW'(pp_ll)
         + (PW'(pp_lh) <<< LB)
         + (PW'(pp_hl) <<< LA)
         + (PW'(pp_hh) <<< (LA + LB));
    end
  end

endmodule

### hw/rtl/nmk_rndsat.sv
// Registered round-to-nearest and saturate stage for a wide signed sum.
`timescale 1ns / 1ps

module nmk_rndsat #(
  parameter int IW   = 82,
  parameter int OW   = 32,
  parameter int FRAC = 24
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [IW-1:0] sum,
  output logic signed [OW-1:0] res,
  output logic                 clip
);

  localparam logic signed [IW:0]   HALF = (IW+1)'(1) <<< (FRAC - 1);
  localparam logic signed [OW-1:0] OMAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic signed [OW-1:0] OMIN = {1'b1, {(OW-1){1'b0}}};

  logic signed [IW:0]      rnd;
  logic [IW-FRAC:0]        sh;
  logic [IW-FRAC:OW-1]     top_bits;
  logic                    in_range;
  logic signed [OW-1:0]    res_next;

  always_comb begin
    rnd      = (IW+1)'(sum) + HALF;
    sh       = rnd[IW:FRAC];
    top_bits = sh[IW-FRAC:OW-1];
    // in range when every bit above the result's sign matches it
    in_range = (&top_bits) | ~(|top_bits);
    if (in_range) begin
      res_next = $signed(sh[OW-1:0]);
    end else if (sh[IW-FRAC]) begin
      res_next = OMIN;
    end else begin
      res_next = OMAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res  <= res_next;
      clip <= ~in_range;
    end
  end

endmodule

### hw/rtl/newmark_acc_vel_update.sv
// Top level of the Newmark-beta acceleration and velocity update pipeline.
`timescale 1ns / 1ps
//
// Usage: each request on the input channel (in_valid/in_ready/in_data) carries
// one degree of freedom: new and old displacement, old velocity and old
// acceleration, signed Q16.16. Each request yields exactly one result on the
// output channel (out_valid/out_ready/out_data): new acceleration, new velocity
// and a flag that is set when either value was clipped to the 32-bit range.
// The five Q24.24 coefficients are written through the cfg channel
// (cfg_valid/cfg_ready/cfg_index/cfg_data); cfg_ready is always high and writes
// to an index past the last register are dropped. Write coefficients only while
// no request is in flight.
// Pipeline: nine register stages. Throughput: one request per cycle while the
// receiver keeps out_ready high, set by the fully pipelined partial-product
// multipliers (two stages each) and round/saturate stages.
// Stall: every stage holds its own valid bit and advances when the stage after
// it is empty or advancing, so a stalled receiver holds the output register
// while bubbles further up still fill; in_ready drops only when every stage is
// full. Reset clears all valid bits and sets all coefficients to zero.

module newmark_acc_vel_update
  import nmk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nmk_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nmk_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  localparam int NS    = 9;                    // register stages
  localparam int DIFFW = DATA_W + 1;           // displacement difference
  localparam int P0W   = COEF_W + DIFFW;       // a0 * diff
  localparam int PW    = COEF_W + DATA_W;      // other products
  localparam int SW    = COEF_W + DATA_W + 2;  // accumulated sums

  // ---------------------------------------------------------------------------
  // Coefficient registers
  // ---------------------------------------------------------------------------
  logic signed [COEF_W-1:0] coef_disp;
  logic signed [COEF_W-1:0] coef_vel_acc;
  logic signed [COEF_W-1:0] coef_acc_acc;
  logic signed [COEF_W-1:0] coef_old_acc_vel;
  logic signed [COEF_W-1:0] coef_new_acc_vel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_disp        <= '0;
      coef_vel_acc     <= '0;
      coef_acc_acc     <= '0;
      coef_old_acc_vel <= '0;
      coef_new_acc_vel <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COEF_DISP:        coef_disp        <= cfg_data;
        REG_COEF_VEL_ACC:     coef_vel_acc     <= cfg_data;
        REG_COEF_ACC_ACC:     coef_acc_acc     <= cfg_data;
        REG_COEF_OLD_ACC_VEL: coef_old_acc_vel <= cfg_data;
        REG_COEF_NEW_ACC_VEL: coef_new_acc_vel <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage valid bits and per-stage advance
  // ---------------------------------------------------------------------------
  logic [NS-1:0] vld;
  logic [NS:0]   adv;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    adv[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      adv[i] = ~vld[i] | adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: capture request, form displacement difference
  // ---------------------------------------------------------------------------
  logic signed [DIFFW-1:0]  diff0;
  logic signed [DATA_W-1:0] vo0;
  logic signed [DATA_W-1:0] ao0;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      diff0 <= DIFFW'(in_data.disp_new) - DIFFW'(in_data.disp_old);
      vo0   <= in_data.vel_old;
      ao0   <= in_data.acc_old;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1-2: four products in parallel
  // ---------------------------------------------------------------------------
  logic signed [P0W-1:0]    p_disp;
  logic signed [PW-1:0]     p_vel;
  logic signed [PW-1:0]     p_acc;
  logic signed [PW-1:0]     p_oacc;
  logic signed [DATA_W-1:0] vo1;
  logic signed [DATA_W-1:0] vo2;

  nmk_mul #(.AW(COEF_W), .BW(DIFFW)) u_mul_disp (
    .clk(clk), .en1(adv[1]), .en2(adv[2]), .a(coef_disp), .b(diff0), .p(p_disp)
  );

  nmk_mul #(.AW(COEF_W), .BW(DATA_W)) u_mul_vel (
    .clk(clk), .en1(adv[1]), .en2(adv[2]), .a(coef_vel_acc), .b(vo0), .p(p_vel)
  );

  nmk_mul #(.AW(COEF_W), .BW(DATA_W)) u_mul_acc (
    .clk(clk), .en1(adv[1]), .en2(adv[2]), .a(coef_acc_acc), .b(ao0), .p(p_acc)
  );

  nmk_mul #(.AW(COEF_W), .BW(DATA_W)) u_mul_oacc (
    .clk(clk), .en1(adv[1]), .en2(adv[2]), .a(coef_old_acc_vel), .b(ao0), .p(p_oacc)
  );

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      vo1 <= vo0;
    end
    if (adv[2]) begin
      vo2 <= vo1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: acceleration sum, velocity partial sum
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] acc_sum3;
  logic signed [SW-1:0] vel_part3;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      acc_sum3  <= SW'(p_disp) - SW'(p_vel) - SW'(p_acc);
      vel_part3 <= (SW'(vo2) <<< COEF_FRAC) + SW'(p_oacc);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: round and saturate the new acceleration
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] acc4;
  logic                     clip_acc4;
  logic signed [SW-1:0]     vel_part4;

  nmk_rndsat #(.IW(SW), .OW(DATA_W), .FRAC(COEF_FRAC)) u_rs_acc (
    .clk(clk), .en(adv[4]), .sum(acc_sum3), .res(acc4), .clip(clip_acc4)
  );

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      vel_part4 <= vel_part3;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 5-6: a7 times the emitted acceleration
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0]     p_nacc;
  logic signed [SW-1:0]     vel_part5;
  logic signed [SW-1:0]     vel_part6;
  logic signed [DATA_W-1:0] acc5;
  logic signed [DATA_W-1:0] acc6;
  logic                     clip5;
  logic                     clip6;

  nmk_mul #(.AW(COEF_W), .BW(DATA_W)) u_mul_nacc (
    .clk(clk), .en1(adv[5]), .en2(adv[6]), .a(coef_new_acc_vel), .b(acc4), .p(p_nacc)
  );

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      vel_part5 <= vel_part4;
      acc5      <= acc4;
      clip5     <= clip_acc4;
    end
    if (adv[6]) begin
      vel_part6 <= vel_part5;
      acc6      <= acc5;
      clip6     <= clip5;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: velocity sum
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0]     vel_sum7;
  logic signed [DATA_W-1:0] acc7;
  logic                     clip7;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      vel_sum7 <= vel_part6 + SW'(p_nacc);
      acc7     <= acc6;
      clip7    <= clip6;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: round and saturate velocity; this is the output register
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] vel8;
  logic                     clip_vel8;
  logic signed [DATA_W-1:0] acc8;
  logic                     clip8;

  nmk_rndsat #(.IW(SW), .OW(DATA_W), .FRAC(COEF_FRAC)) u_rs_vel (
    .clk(clk), .en(adv[8]), .sum(vel_sum7), .res(vel8), .clip(clip_vel8)
  );

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      acc8  <= acc7;
      clip8 <= clip7;
    end
  end

  always_comb begin
    out_data.acc_new   = acc8;
    out_data.vel_new   = vel8;
    out_data.saturated = clip8 | clip_vel8;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // input stalls only when the whole pipe is full behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a stalled output");

  // a set flag means one of the results sits on a range bound
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.saturated) |->
      (out_data.acc_new == DATA_MAX || out_data.acc_new == DATA_MIN ||
       out_data.vel_new == DATA_MAX || out_data.vel_new == DATA_MIN))
    else $error("saturated flag without a clipped result");

  // a clipped acceleration is exactly a bound
  a_acc_clip: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && clip_acc4) |-> (acc4 == DATA_MAX || acc4 == DATA_MIN))
    else $error("acceleration clip without bound value");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule
